>>> rtl/core/mteq_pkg.sv
`default_nettype none
package mteq_pkg;
  localparam logic [2:0] FUNC_CREATE = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_POLL   = 3'd2;
  localparam logic [2:0] FUNC_SETIVL = 3'd3;
  localparam logic [2:0] FUNC_SETREP = 3'd4;
  localparam logic [47:0] DUE_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [47:0] now_ms;
    logic [31:0] timer_id;
    logic [31:0] interval_ms;
    logic [31:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic        ok;
    logic [47:0] first_expire_ms;
    logic [4:0]  active_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic apply;
    logic final_start;
  } dp_cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/mteq_if.sv
`default_nettype none
interface mteq_in_if;
  logic valid;
  logic ready;
  mteq_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mteq_out_if;
  logic valid;
  logic ready;
  mteq_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mteq_datapath.sv
`default_nettype none
module mteq_datapath #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  mteq_pkg::dp_cmd_t cmd,
  input  mteq_pkg::item_t item,
  output logic scan_last,
  output mteq_pkg::result_t result
);
  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  logic [TIMER_SLOTS-1:0] valid_r;
  logic [31:0] id_r [TIMER_SLOTS];
  logic [31:0] ivl_r [TIMER_SLOTS];
  logic [31:0] rep_r [TIMER_SLOTS];
  logic [47:0] due_r [TIMER_SLOTS];
  logic [31:0] next_id_r;
  mteq_pkg::item_t item_r;

  logic [IW-1:0] idx_r;
  logic          best_ok_r, free_ok_r, find_ok_r, found_any_r;
  logic [IW-1:0] best_r, free_r, find_r;
  logic [CW-1:0] cnt_r;
  logic          final_r;

  logic [31:0] rid_r;
  logic        ok_r;

  logic [48:0] sum_now;
  logic [47:0] due_now;
  logic [48:0] sum_ivl;
  logic [47:0] due_rearm;
  logic [31:0] rep_dec;
  logic        cur_v;

  assign cur_v = valid_r[idx_r];
  assign scan_last = (idx_r == IW'(TIMER_SLOTS - 1));
  assign sum_now = {1'b0, item_r.now_ms} + {17'd0, item_r.interval_ms};
  assign due_now = sum_now[48] ? mteq_pkg::DUE_MAX : sum_now[47:0];
  assign sum_ivl = {1'b0, item_r.now_ms} + {17'd0, ivl_r[best_r]};
  assign due_rearm = sum_ivl[48] ? mteq_pkg::DUE_MAX : sum_ivl[47:0];
  assign rep_dec = rep_r[best_r] - 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      next_id_r <= 32'd1;
      idx_r <= '0;
      best_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
      find_ok_r <= 1'b0;
      found_any_r <= 1'b0;
      cnt_r <= '0;
      final_r <= 1'b0;
      rid_r <= '0;
      ok_r <= 1'b0;
    end else begin
      if (cmd.load) item_r <= item;
      if (cmd.scan_start || cmd.final_start) begin
        idx_r <= '0;
        best_ok_r <= 1'b0;
        free_ok_r <= 1'b0;
        find_ok_r <= 1'b0;
        found_any_r <= 1'b0;
        cnt_r <= '0;
        final_r <= cmd.final_start;
      end else if (cmd.scan_step) begin
        if (!scan_last) idx_r <= idx_r + IW'(1);
        if (cur_v) begin
          cnt_r <= cnt_r + CW'(1);
          if (!best_ok_r || due_r[idx_r] < due_r[best_r]) begin
            best_ok_r <= 1'b1;
            best_r <= idx_r;
          end
          if (id_r[idx_r] == item_r.timer_id) begin
            if (!find_ok_r) begin
              find_ok_r <= 1'b1;
              find_r <= idx_r;
            end
            if (!final_r && item_r.func == mteq_pkg::FUNC_REMOVE) begin
              valid_r[idx_r] <= 1'b0;
              found_any_r <= 1'b1;
            end
          end
        end else if (!free_ok_r) begin
          free_ok_r <= 1'b1;
          free_r <= idx_r;
        end
      end
      if (cmd.apply) begin
        rid_r <= '0;
        ok_r <= 1'b0;
        case (item_r.func)
          mteq_pkg::FUNC_CREATE: begin
            if (item_r.interval_ms != '0 && free_ok_r) begin
              valid_r[free_r] <= 1'b1;
              id_r[free_r] <= next_id_r;
              ivl_r[free_r] <= item_r.interval_ms;
              rep_r[free_r] <= item_r.repeat_count;
              due_r[free_r] <= due_now;
              rid_r <= next_id_r;
              ok_r <= 1'b1;
              next_id_r <= (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 32'd1;
            end
          end
          mteq_pkg::FUNC_REMOVE: ok_r <= found_any_r;
          mteq_pkg::FUNC_POLL: begin
            if (best_ok_r && due_r[best_r] <= item_r.now_ms) begin
              rid_r <= id_r[best_r];
              ok_r <= 1'b1;
              if (!rep_r[best_r][31] && rep_r[best_r] != '0) begin
                rep_r[best_r] <= rep_dec;
                if (rep_dec == '0) valid_r[best_r] <= 1'b0;
                else due_r[best_r] <= due_rearm;
              end else begin
                due_r[best_r] <= due_rearm;
              end
            end
          end
          mteq_pkg::FUNC_SETIVL: begin
            if (find_ok_r) begin
              ivl_r[find_r] <= item_r.interval_ms;
              due_r[find_r] <= due_now;
              ok_r <= 1'b1;
            end
          end
          mteq_pkg::FUNC_SETREP: begin
            if (find_ok_r) begin
              rep_r[find_r] <= item_r.repeat_count;
              ok_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    result.result_id = rid_r;
    result.ok = ok_r;
    result.first_expire_ms = best_ok_r ? due_r[best_r] : mteq_pkg::DUE_MAX;
    if (CW > 5 && cnt_r > CW'(31)) result.active_count = 5'd31;
    else result.active_count = 5'(cnt_r);
  end
endmodule
`default_nettype wire

>>> rtl/core/mteq_ctrl.sv
`default_nettype none
module mteq_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire logic scan_last,
  output mteq_pkg::dp_cmd_t cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_SCAN2 = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.scan_step = 1'b1;
        if (scan_last) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        cmd.final_start = 1'b1;
        state_nxt = S_SCAN2;
      end
      S_SCAN2: begin
        cmd.scan_step = 1'b1;
        if (scan_last) state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/core/multi_timer_expiry_queue_top.sv
`default_nettype none
// Timer table of TIMER_SLOTS slots driven by one operation per transfer.
// in: valid/ready channel carrying func, now_ms, timer_id, interval_ms and
//   repeat_count. out: valid/ready channel carrying result_id, ok,
//   first_expire_ms and active_count; one result per input transfer.
// After an input transfer the control steps through S_SCAN1, S_APPLY and
//   S_SCAN2 to S_OUT, where out_valid rises. One slot is visited per cycle
//   in a scan before the operation (lowest free slot, id match, earliest
//   due) and in a second scan after it (earliest due and occupancy), so the
//   sequential slot scan sets the rate at which items are processed.
// One item is in flight at a time; in_ready is low until the result is
//   taken. While out_ready is low the result holds steady.
// Reset: all slots free, next id is 1, no result pending.
module multi_timer_expiry_queue_top #(
  parameter int TIMER_SLOTS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  mteq_in_if.sink in_ch,
  mteq_out_if.source out_ch
);
  mteq_pkg::dp_cmd_t cmd;
  logic scan_last;

  mteq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .scan_last, .cmd
  );

  mteq_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .item(in_ch.data), .scan_last, .result(out_ch.data)
  );
endmodule
`default_nettype wire
